### design/search_hash_table_probe_store_top_assert.svh
// Assertion macros for the probe/store table and its checker.
// Expects clk and arst_n in the scope where a macro is used.
`ifndef SEARCH_HASH_TABLE_PROBE_STORE_TOP_ASSERT_SVH
`define SEARCH_HASH_TABLE_PROBE_STORE_TOP_ASSERT_SVH

// same-cycle implication
`define SHTPS_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define SHTPS_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

### design/shtps_pkg.sv
// Shared types and constants for the probe/store table.
// No dependencies; imported by the top level, front, queue and back modules.
package shtps_pkg;

	localparam int unsigned DEF_ENTRIES    = 65536;
	localparam int unsigned DEF_INF_SCORE  = 50000;
	localparam int unsigned DEF_MATE_BOUND = 49000;
	localparam int unsigned BIAS_MARGIN    = 1000;

	localparam logic [16:0] FIELD17   = 17'h1FFFF;
	localparam int unsigned SCORE_W   = 19;
	localparam int unsigned PK_W      = 25;
	localparam int unsigned DEPTH_LSB = 17;
	localparam int unsigned KIND_LSB  = 23;

	localparam logic CMD_PROBE = 1'b0;
	localparam logic CMD_STORE = 1'b1;

	localparam logic [1:0] KIND_EXACT = 2'd0;
	localparam logic [1:0] KIND_UPPER = 2'd1;
	localparam logic [1:0] KIND_LOWER = 2'd2;

	typedef enum logic [1:0] {
		F_IDLE,
		F_MOD,
		F_PUSH
	} front_state_t;

	typedef enum logic [1:0] {
		B_CLEAR,
		B_IDLE,
		B_EVAL
	} back_state_t;

	typedef struct packed {
		logic               cmd;
		logic [63:0]        key;
		logic signed [16:0] alpha;
		logic signed [16:0] beta;
		logic [5:0]         req_depth;
		logic [1:0]         bound_kind;
		logic [5:0]         ply;
		logic [PK_W-1:0]    new_pk;
	} item_t;

	typedef struct packed {
		logic full;
		logic empty;
	} fifo_stat_t;

	typedef struct packed {
		logic            valid;
		logic [7:0]      age;
		logic [PK_W-1:0] pk;
		logic [63:0]     check;
	} ent_t;

endpackage

### design/search_hash_table_probe_store_top.sv
// Direct-mapped position table with XOR check words: probe and store requests.
// Channels: request in (in_valid/in_stall), result out (out_valid/out_stall),
// age register write (cfg_valid/cfg_ready, always ready).
// One result per request: found/value for a probe, replaced for a store,
// filled (saturating count of replacing stores) for both.
// Path: the front part registers the request and pushes it into the queue;
// the back part pops it, reads the table entry and registers the result.
// When ENTRIES is not a power of two the key is first reduced in the front
// part's F_MOD state, in which it takes no new request. The back part handles
// one request at a time by a single-port read-then-write of the table memory;
// the front part takes the next request meanwhile, through a two-entry queue.
// Reset: control state clears at once, then a sweep writes every table entry
// empty, one entry per cycle (ENTRIES entries, 65536 by default); in_stall is
// high during the sweep. Age writes are taken at any time.
// Out stall: the result register holds; the queue and front keep accepting
// until full, then in_stall rises.
// Depends on shtps_pkg, shtps_front, shtps_fifo, shtps_back.
module search_hash_table_probe_store_top #(
	parameter int unsigned ENTRIES    = shtps_pkg::DEF_ENTRIES,
	parameter int unsigned INF_SCORE  = shtps_pkg::DEF_INF_SCORE,
	parameter int unsigned MATE_BOUND = shtps_pkg::DEF_MATE_BOUND
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cfg_valid,
	output logic               cfg_ready,
	input  logic [7:0]         cfg_data,
	input  logic               in_valid,
	output logic               in_stall,
	input  logic               cmd,
	input  logic [63:0]        key,
	input  logic signed [16:0] alpha,
	input  logic signed [16:0] beta,
	input  logic [5:0]         req_depth,
	input  logic signed [16:0] new_score,
	input  logic [1:0]         bound_kind,
	input  logic [5:0]         ply,
	output logic               out_valid,
	input  logic               out_stall,
	output logic               found,
	output logic signed [16:0] value,
	output logic               replaced,
	output logic [16:0]        filled
);
	import shtps_pkg::*;

	localparam int unsigned IDX_W = $clog2(ENTRIES);
	localparam int unsigned Q_W   = IDX_W + $bits(item_t);

	logic [7:0]       current_age_q;
	logic             clearing;
	logic             push;
	logic             pop;
	item_t            push_item;
	item_t            pop_item;
	logic [IDX_W-1:0] push_idx;
	logic [IDX_W-1:0] pop_idx;
	logic [Q_W-1:0]   q_pop_data;
	fifo_stat_t       fifo_stat;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			current_age_q <= 8'd0;
		end else if (cfg_valid && cfg_ready) begin
			current_age_q <= cfg_data;
		end
	end

	shtps_front #(
		.ENTRIES    (ENTRIES),
		.INF_SCORE  (INF_SCORE),
		.MATE_BOUND (MATE_BOUND)
	) u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_stall   (in_stall),
		.cmd        (cmd),
		.key        (key),
		.alpha      (alpha),
		.beta       (beta),
		.req_depth  (req_depth),
		.new_score  (new_score),
		.bound_kind (bound_kind),
		.ply        (ply),
		.clearing   (clearing),
		.fifo_stat  (fifo_stat),
		.push       (push),
		.push_item  (push_item),
		.push_idx   (push_idx)
	);

	shtps_fifo #(
		.W (Q_W)
	) u_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_data ({push_idx, push_item}),
		.pop       (pop),
		.pop_data  (q_pop_data),
		.stat      (fifo_stat)
	);

	assign pop_idx  = q_pop_data[Q_W-1 -: IDX_W];
	assign pop_item = q_pop_data[$bits(item_t)-1:0];

	shtps_back #(
		.ENTRIES    (ENTRIES),
		.INF_SCORE  (INF_SCORE),
		.MATE_BOUND (MATE_BOUND)
	) u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.current_age (current_age_q),
		.fifo_stat   (fifo_stat),
		.pop_item    (pop_item),
		.pop_idx     (pop_idx),
		.pop         (pop),
		.clearing    (clearing),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.found       (found),
		.value       (value),
		.replaced    (replaced),
		.filled      (filled)
	);

endmodule

### design/shtps_fifo.sv
// Two-entry request queue between front and back parts.
// Depends on shtps_pkg for the status struct.
module shtps_fifo #(
	parameter int unsigned W = 8
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   push,
	input  logic [W-1:0]           push_data,
	input  logic                   pop,
	output logic [W-1:0]           pop_data,
	output shtps_pkg::fifo_stat_t  stat
);
	import shtps_pkg::*;

	logic [W-1:0] data_q [2];
	logic         wptr_q;
	logic         rptr_q;
	logic [1:0]   cnt_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q <= 1'b0;
			rptr_q <= 1'b0;
			cnt_q  <= 2'd0;
		end else begin
			if (push) wptr_q <= ~wptr_q;
			if (pop) rptr_q <= ~rptr_q;
			case ({push, pop})
				2'b10:   cnt_q <= cnt_q + 2'd1;
				2'b01:   cnt_q <= cnt_q - 2'd1;
				default: cnt_q <= cnt_q;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (push) data_q[wptr_q] <= push_data;
	end

	assign pop_data   = data_q[rptr_q];
	assign stat.full  = (cnt_q == 2'd2);
	assign stat.empty = (cnt_q == 2'd0);

endmodule

### design/shtps_front.sv
// Front part: takes requests, packs the store word and reduces the key to an index.
// Depends on shtps_pkg; feeds shtps_fifo.
module shtps_front #(
	parameter int unsigned ENTRIES    = shtps_pkg::DEF_ENTRIES,
	parameter int unsigned INF_SCORE  = shtps_pkg::DEF_INF_SCORE,
	parameter int unsigned MATE_BOUND = shtps_pkg::DEF_MATE_BOUND,
	localparam int unsigned IDX_W     = $clog2(ENTRIES)
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   in_valid,
	output logic                   in_stall,
	input  logic                   cmd,
	input  logic [63:0]            key,
	input  logic signed [16:0]     alpha,
	input  logic signed [16:0]     beta,
	input  logic [5:0]             req_depth,
	input  logic signed [16:0]     new_score,
	input  logic [1:0]             bound_kind,
	input  logic [5:0]             ply,
	input  logic                   clearing,
	input  shtps_pkg::fifo_stat_t  fifo_stat,
	output logic                   push,
	output shtps_pkg::item_t       push_item,
	output logic [IDX_W-1:0]       push_idx
);
	import shtps_pkg::*;

	localparam bit POW2 = ((ENTRIES & (ENTRIES - 1)) == 0);
	localparam int unsigned X_W = IDX_W + 11;
	localparam int unsigned H_W = 12;
	localparam logic [IDX_W+1:0] ENT = (IDX_W + 2)'(ENTRIES);
	localparam logic [H_W-1:0] RECIP =
		H_W'((64'd1 << (H_W + IDX_W - 1)) / 64'(ENTRIES));
	localparam logic [7:0][IDX_W-1:0] WGT = {
		IDX_W'((64'd1 << 56) % 64'(ENTRIES)),
		IDX_W'((64'd1 << 48) % 64'(ENTRIES)),
		IDX_W'((64'd1 << 40) % 64'(ENTRIES)),
		IDX_W'((64'd1 << 32) % 64'(ENTRIES)),
		IDX_W'((64'd1 << 24) % 64'(ENTRIES)),
		IDX_W'((64'd1 << 16) % 64'(ENTRIES)),
		IDX_W'((64'd1 << 8) % 64'(ENTRIES)),
		IDX_W'(64'd1 % 64'(ENTRIES))
	};
	localparam logic signed [SCORE_W-1:0] MATE_S = SCORE_W'(MATE_BOUND);
	localparam logic signed [SCORE_W-1:0] BIAS_S = SCORE_W'(INF_SCORE + BIAS_MARGIN);
	localparam logic signed [SCORE_W-1:0] F_MAX  = SCORE_W'(FIELD17);
	localparam logic [1:0] STEP_LAST = 2'd3;

	front_state_t state_q, state_d;
	logic         accept;
	item_t        item_q;
	logic [IDX_W-1:0] rem_q;
	logic [1:0]   cnt_q;
	logic [X_W-1:0]   sum_q;
	logic [H_W-1:0]   qest_q;
	logic [IDX_W+1:0] diff_q;
	logic [X_W-1:0]   fold;
	logic [2*H_W-1:0] qprod;
	logic [X_W-1:0]   diff_full;
	logic [IDX_W+1:0] red1, red2;

	logic signed [SCORE_W-1:0] sc, adj, f;
	logic signed [SCORE_W-1:0] ply_s;
	logic [PK_W-1:0] pk_new;

	// store word: move mate scores away from the root, bias, saturate
	always_comb begin
		sc    = {{(SCORE_W - 17){new_score[16]}}, new_score};
		ply_s = {{(SCORE_W - 6){1'b0}}, ply};
		adj   = sc;
		if (sc < -MATE_S) adj = sc - ply_s;
		else if (sc > MATE_S) adj = sc + ply_s;
		f = adj + BIAS_S;
		if (f < 0) f = '0;
		else if (f > F_MAX) f = F_MAX;
		pk_new = {bound_kind, req_depth, f[16:0]};
	end

	// fold key bytes by their weights, estimate the quotient by a reciprocal,
	// then at most two subtracts of the modulus
	always_comb begin
		fold = '0;
		for (int i = 0; i < 8; i++)
			fold = fold + X_W'(item_q.key[8*i +: 8]) * X_W'(WGT[i]);
		qprod     = (2 * H_W)'(sum_q[X_W-1 -: H_W]) * (2 * H_W)'(RECIP);
		diff_full = sum_q - X_W'(qest_q) * X_W'(ENTRIES);
		red1      = (diff_q >= ENT) ? (diff_q - ENT) : diff_q;
		red2      = (red1 >= ENT) ? (red1 - ENT) : red1;
	end

	always_comb begin
		state_d = state_q;
		accept  = 1'b0;
		push    = 1'b0;
		case (state_q)
			F_IDLE: begin
				accept = in_valid && !clearing;
				if (accept) state_d = POW2 ? F_PUSH : F_MOD;
			end
			F_MOD: begin
				if (cnt_q == STEP_LAST) state_d = F_PUSH;
			end
			F_PUSH: begin
				if (!fifo_stat.full) begin
					push   = 1'b1;
					accept = in_valid && !clearing;
					if (accept) state_d = POW2 ? F_PUSH : F_MOD;
					else state_d = F_IDLE;
				end
			end
			default: state_d = F_IDLE;
		endcase
	end

	assign in_stall = clearing ||
		!((state_q == F_IDLE) || ((state_q == F_PUSH) && !fifo_stat.full));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= F_IDLE;
			cnt_q   <= 2'd0;
		end else begin
			state_q <= state_d;
			if (accept) cnt_q <= 2'd0;
			else if (state_q == F_MOD) cnt_q <= cnt_q + 2'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			item_q.cmd        <= cmd;
			item_q.key        <= key;
			item_q.alpha      <= alpha;
			item_q.beta       <= beta;
			item_q.req_depth  <= req_depth;
			item_q.bound_kind <= bound_kind;
			item_q.ply        <= ply;
			item_q.new_pk     <= pk_new;
		end
		if (state_q == F_MOD) begin
			sum_q  <= fold;
			qest_q <= qprod[2*H_W-1 -: H_W];
			diff_q <= diff_full[IDX_W+1:0];
			rem_q  <= red2[IDX_W-1:0];
		end
	end

	assign push_item = item_q;
	assign push_idx  = POW2 ? item_q.key[IDX_W-1:0] : rem_q;

endmodule

### design/shtps_back.sv
// Back part: table memory, clearing sweep, probe/store evaluation and result register.
// Depends on shtps_pkg; drains shtps_fifo.
module shtps_back #(
	parameter int unsigned ENTRIES    = shtps_pkg::DEF_ENTRIES,
	parameter int unsigned INF_SCORE  = shtps_pkg::DEF_INF_SCORE,
	parameter int unsigned MATE_BOUND = shtps_pkg::DEF_MATE_BOUND,
	localparam int unsigned IDX_W     = $clog2(ENTRIES)
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic [7:0]             current_age,
	input  shtps_pkg::fifo_stat_t  fifo_stat,
	input  shtps_pkg::item_t       pop_item,
	input  logic [IDX_W-1:0]       pop_idx,
	output logic                   pop,
	output logic                   clearing,
	output logic                   out_valid,
	input  logic                   out_stall,
	output logic                   found,
	output logic signed [16:0]     value,
	output logic                   replaced,
	output logic [16:0]            filled
);
	import shtps_pkg::*;

	localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(ENTRIES - 1);
	localparam int unsigned FILL_CAP = (ENTRIES < 131071) ? ENTRIES : 131071;
	localparam logic [16:0] FILL_MAX = 17'(FILL_CAP);
	localparam logic signed [SCORE_W-1:0] MATE_S  = SCORE_W'(MATE_BOUND);
	localparam logic signed [SCORE_W-1:0] BIAS_S  = SCORE_W'(INF_SCORE + BIAS_MARGIN);
	localparam logic signed [SCORE_W-1:0] VAL_MAX = SCORE_W'(65535);
	localparam logic signed [SCORE_W-1:0] VAL_MIN = -SCORE_W'(65536);

	ent_t mem [ENTRIES];
	ent_t rdata_q;

	back_state_t      state_q, state_d;
	logic [IDX_W-1:0] clr_idx_q;
	item_t            cur_q;
	logic [IDX_W-1:0] cur_idx_q;
	logic [16:0]      fill_q;
	logic             out_valid_q;

	logic             mem_we;
	logic             mem_re;
	logic [IDX_W-1:0] mem_waddr;
	ent_t             mem_wdata;
	logic             advance;
	logic             out_free;

	logic             take;
	logic             store_take;
	logic             probe_found;
	logic signed [16:0] probe_value;
	logic signed [SCORE_W-1:0] s, s_adj, ply_s, alpha_s, beta_s;
	logic [16:0]      fill_nxt;

	assign out_free = !out_valid_q || !out_stall;
	assign clearing = (state_q == B_CLEAR);

	// probe answer from the stored word
	always_comb begin
		s       = $signed({{(SCORE_W - 17){1'b0}}, rdata_q.pk[16:0]}) - BIAS_S;
		ply_s   = {{(SCORE_W - 6){1'b0}}, cur_q.ply};
		alpha_s = {{(SCORE_W - 17){cur_q.alpha[16]}}, cur_q.alpha};
		beta_s  = {{(SCORE_W - 17){cur_q.beta[16]}}, cur_q.beta};
		s_adj   = s;
		if (s < -MATE_S) s_adj = s + ply_s;
		else if (s > MATE_S) s_adj = s - ply_s;
		probe_found = 1'b0;
		probe_value = '0;
		if (rdata_q.valid && (rdata_q.check == (cur_q.key ^ {39'd0, rdata_q.pk})) &&
			(rdata_q.pk[DEPTH_LSB +: 6] >= cur_q.req_depth)) begin
			case (rdata_q.pk[KIND_LSB +: 2])
				KIND_EXACT: begin
					probe_found = 1'b1;
					if (s_adj > VAL_MAX) probe_value = VAL_MAX[16:0];
					else if (s_adj < VAL_MIN) probe_value = VAL_MIN[16:0];
					else probe_value = s_adj[16:0];
				end
				KIND_UPPER: begin
					if (s_adj <= alpha_s) begin
						probe_found = 1'b1;
						probe_value = cur_q.alpha;
					end
				end
				KIND_LOWER: begin
					if (s_adj >= beta_s) begin
						probe_found = 1'b1;
						probe_value = cur_q.beta;
					end
				end
				default: probe_found = 1'b0;
			endcase
		end
	end

	// replacement: empty, stale generation, or no deeper than the new depth
	always_comb begin
		take = !rdata_q.valid || (rdata_q.age < current_age) ||
			(rdata_q.pk[DEPTH_LSB +: 6] <= cur_q.req_depth);
		store_take = (cur_q.cmd == CMD_STORE) && take;
		fill_nxt = (store_take && (fill_q < FILL_MAX)) ? (fill_q + 17'd1) : fill_q;
	end

	always_comb begin
		state_d = state_q;
		mem_we  = 1'b0;
		mem_re  = 1'b0;
		pop     = 1'b0;
		advance = 1'b0;
		case (state_q)
			B_CLEAR: begin
				mem_we = 1'b1;
				if (clr_idx_q == IDX_LAST) state_d = B_IDLE;
			end
			B_IDLE: begin
				if (!fifo_stat.empty) begin
					pop     = 1'b1;
					mem_re  = 1'b1;
					state_d = B_EVAL;
				end
			end
			B_EVAL: begin
				if (out_free) begin
					advance = 1'b1;
					mem_we  = store_take;
					state_d = B_IDLE;
				end
			end
			default: state_d = B_IDLE;
		endcase
	end

	always_comb begin
		if (state_q == B_CLEAR) begin
			mem_waddr = clr_idx_q;
			mem_wdata = '0;
		end else begin
			mem_waddr       = cur_idx_q;
			mem_wdata.valid = 1'b1;
			mem_wdata.age   = current_age;
			mem_wdata.pk    = cur_q.new_pk;
			mem_wdata.check = cur_q.key ^ {39'd0, cur_q.new_pk};
		end
	end

	always_ff @(posedge clk) begin
		if (mem_we) mem[mem_waddr] <= mem_wdata;
		if (mem_re) rdata_q <= mem[pop_idx];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= B_CLEAR;
			clr_idx_q   <= '0;
			fill_q      <= 17'd0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (state_q == B_CLEAR) clr_idx_q <= clr_idx_q + 1'b1;
			if (advance) begin
				fill_q      <= fill_nxt;
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			cur_q     <= pop_item;
			cur_idx_q <= pop_idx;
		end
		if (advance) begin
			found    <= (cur_q.cmd == CMD_PROBE) && probe_found;
			value    <= (cur_q.cmd == CMD_PROBE) ? probe_value : 17'sd0;
			replaced <= store_take;
			filled   <= fill_nxt;
		end
	end

	assign out_valid = out_valid_q;

endmodule

### design/shtps_checker.sv
// Port-level checks for the probe/store table, bound to the top level.
// Depends on search_hash_table_probe_store_top_assert.svh.
`include "search_hash_table_probe_store_top_assert.svh"

module shtps_checker (
	input logic               clk,
	input logic               arst_n,
	input logic               out_valid,
	input logic               out_stall,
	input logic               found,
	input logic signed [16:0] value,
	input logic               replaced,
	input logic [16:0]        filled
);

	// hold a stalled result
	`SHTPS_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid && $stable(value) && $stable(filled), "stalled result changed")

	// a request is either a probe hit or a store write, never both
	`SHTPS_ASSERT_NOW(a_found_excl, out_valid && found, !replaced, "found and replaced together")

	// a miss or a store reports a zero value
	`SHTPS_ASSERT_NOW(a_miss_zero, out_valid && !found, value == 17'sd0, "nonzero value on miss")

	// a replacing store always leaves a nonzero fill count
	`SHTPS_ASSERT_NOW(a_fill_nz, out_valid && replaced, filled != 17'd0, "zero fill after store")

endmodule

bind search_hash_table_probe_store_top shtps_checker u_chk (.*);
